>>> hw/rtl/fped_pkg.sv
// Shared constants, register codes and state types of the frame peak energy detector.
package fped_pkg;

    localparam int DEF_MAX_WINDOW_FRAMES = 256;
    localparam int DEF_MAX_FRAME_SIZE    = 4096;
    localparam int DEF_SAMPLE_BITS       = 16;

    localparam int FRAME_SIZE_W = 13;
    localparam int PEAK_START_W = 8;
    localparam int WINDOW_W     = 9;
    localparam int PEAK_THR_W   = 16;
    localparam int ENERGY_THR_W = 31;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [FRAME_SIZE_W-1:0]      RST_FRAME_SIZE = 13'd1600;
    localparam logic [PEAK_START_W-1:0]      RST_PEAK_START = 8'd3;
    localparam logic [WINDOW_W-1:0]          RST_WINDOW     = 9'd130;
    localparam logic signed [PEAK_THR_W-1:0] RST_PEAK_THR   = 16'sd29000;
    localparam logic [ENERGY_THR_W-1:0]      RST_ENERGY_THR = 31'd500000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_SIZE = 3'd0,
        CFG_PEAK_START = 3'd1,
        CFG_WINDOW     = 3'd2,
        CFG_PEAK_THR   = 3'd3,
        CFG_ENERGY_THR = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_FE_READ,
        ST_FE_EVICT,
        ST_FE_COMMIT,
        ST_THR_W,
        ST_THR_FS,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        WIN_NOP,
        WIN_READ,
        WIN_EVICT,
        WIN_COMMIT
    } t_win_op;

endpackage

>>> hw/rtl/fped_if.sv
// Channel interfaces: sample input, result output and configuration write.
interface fped_sample_if import fped_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface fped_result_if ();
    logic valid;
    logic ready;
    logic detected;
    logic peak_hit;
    logic energy_hit;

    modport source (output valid, output detected, output peak_hit, output energy_hit,
                    input ready);
    modport sink (input valid, input detected, input peak_hit, input energy_hit,
                  output ready);
endinterface

interface fped_cfg_if import fped_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/fped_cfg_regs.sv
// Configuration registers with range clamping of frame size and window length.
module fped_cfg_regs import fped_pkg::*; #(
    parameter int MAX_WINDOW_FRAMES = DEF_MAX_WINDOW_FRAMES,
    parameter int MAX_FRAME_SIZE    = DEF_MAX_FRAME_SIZE,
    parameter int FS_W              = $clog2(MAX_FRAME_SIZE + 1),
    parameter int WIN_W             = $clog2(MAX_WINDOW_FRAMES + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fped_cfg_if.sink                     i_cfg,
    output logic [FS_W-1:0]              o_frame_size,
    output logic [WIN_W-1:0]             o_window,
    output logic [PEAK_START_W-1:0]      o_peak_start,
    output logic signed [PEAK_THR_W-1:0] o_peak_thr,
    output logic [ENERGY_THR_W-1:0]      o_energy_thr
);

    logic [FRAME_SIZE_W-1:0]      r_frame_size;
    logic [PEAK_START_W-1:0]      r_peak_start;
    logic [WINDOW_W-1:0]          r_window;
    logic signed [PEAK_THR_W-1:0] r_peak_thr;
    logic [ENERGY_THR_W-1:0]      r_energy_thr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= RST_FRAME_SIZE;
            r_peak_start <= RST_PEAK_START;
            r_window     <= RST_WINDOW;
            r_peak_thr   <= RST_PEAK_THR;
            r_energy_thr <= RST_ENERGY_THR;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_SIZE: r_frame_size <= i_cfg.data[FRAME_SIZE_W-1:0];
                CFG_PEAK_START: r_peak_start <= i_cfg.data[PEAK_START_W-1:0];
                CFG_WINDOW:     r_window     <= i_cfg.data[WINDOW_W-1:0];
                CFG_PEAK_THR:   r_peak_thr   <= i_cfg.data[PEAK_THR_W-1:0];
                CFG_ENERGY_THR: r_energy_thr <= i_cfg.data[ENERGY_THR_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero setting counts as one; settings above the maximum count as the maximum.
    always_comb begin
        priority if (r_frame_size == '0) begin
            o_frame_size = FS_W'(1);
        end else if (32'(r_frame_size) > 32'(MAX_FRAME_SIZE)) begin
            o_frame_size = FS_W'(MAX_FRAME_SIZE);
        end else begin
            o_frame_size = FS_W'(r_frame_size);
        end

        priority if (r_window == '0) begin
            o_window = WIN_W'(1);
        end else if (32'(r_window) > 32'(MAX_WINDOW_FRAMES)) begin
            o_window = WIN_W'(MAX_WINDOW_FRAMES);
        end else begin
            o_window = WIN_W'(r_window);
        end
    end

    assign o_peak_start = r_peak_start;
    assign o_peak_thr   = r_peak_thr;
    assign o_energy_thr = r_energy_thr;

endmodule

>>> hw/rtl/fped_sermul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, product shifts right.
module fped_sermul import fped_pkg::*; #(
    parameter int MC_W = 40,
    parameter int MP_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MC_W-1:0]      i_mcand,
    input  logic [MP_W-1:0]      i_mplier,
    output logic                 o_done,
    output logic [MC_W+MP_W-1:0] o_product
);

    localparam int PR_W  = MC_W + MP_W;
    localparam int CNT_W = $clog2(MP_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MC_W-1:0]  r_mc;
    logic [PR_W-1:0]  r_acc;
    logic [MC_W:0]    sum_hi;

    // The multiplier sits in the low bits of the accumulator and leaves it one
    // bit per cycle while the partial product moves in from the top.
    assign sum_hi = {1'b0, r_acc[PR_W-1:MP_W]} + (r_acc[0] ? {1'b0, r_mc} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc  <= i_mcand;
            r_acc <= {{MC_W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_acc <= {sum_hi, r_acc[MP_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

>>> hw/rtl/fped_window.sv
// Ring of recent frame energies with the running window sum and frame count.
module fped_window import fped_pkg::*; #(
    parameter int MAX_WINDOW_FRAMES = DEF_MAX_WINDOW_FRAMES,
    parameter int FE_W              = 43,
    parameter int WS_W              = 51,
    parameter int WIN_W             = $clog2(MAX_WINDOW_FRAMES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_win_op          i_op,
    input  logic [WIN_W-1:0] i_window,
    input  logic [FE_W-1:0]  i_frame_energy,
    output logic [WIN_W-1:0] o_frames_seen,
    output logic [WS_W-1:0]  o_window_sum
);

    localparam int PTR_W = $clog2(MAX_WINDOW_FRAMES);

    logic [FE_W-1:0]  ring [MAX_WINDOW_FRAMES];
    logic [FE_W-1:0]  r_rd_data;
    logic             r_evict;
    logic [PTR_W-1:0] r_ptr;
    logic [WIN_W-1:0] r_frames_seen;
    logic [WS_W-1:0]  r_window_sum;
    logic [31:0]      old_full;
    logic [PTR_W-1:0] old_addr;

    // Entry that leaves the window: window frames behind the write pointer.
    always_comb begin
        if (32'(r_ptr) >= 32'(i_window)) begin
            old_full = 32'(r_ptr) - 32'(i_window);
        end else begin
            old_full = 32'(r_ptr) + 32'(MAX_WINDOW_FRAMES) - 32'(i_window);
        end
    end
    assign old_addr = old_full[PTR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_op == WIN_READ) begin
            r_rd_data <= ring[old_addr];
        end
        if (i_op == WIN_COMMIT) begin
            ring[r_ptr] <= i_frame_energy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evict       <= 1'b0;
            r_ptr         <= '0;
            r_frames_seen <= '0;
            r_window_sum  <= '0;
        end else begin
            unique case (i_op)
                WIN_READ: begin
                    r_evict <= (r_frames_seen >= i_window);
                end
                WIN_EVICT: begin
                    if (r_evict) begin
                        r_window_sum <= r_window_sum - WS_W'(r_rd_data);
                    end
                end
                WIN_COMMIT: begin
                    r_window_sum <= r_window_sum + WS_W'(i_frame_energy);
                    r_ptr <= (r_ptr == PTR_W'(MAX_WINDOW_FRAMES - 1)) ? '0 : r_ptr + 1'b1;
                    if (r_frames_seen != WIN_W'(MAX_WINDOW_FRAMES)) begin
                        r_frames_seen <= r_frames_seen + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_frames_seen = r_frames_seen;
    assign o_window_sum  = r_window_sum;

endmodule

>>> hw/rtl/frame_peak_energy_detector.sv
// Top level of the frame peak and energy detector: frame sequencer and result register.
//
//   channel   direction  beat carries                          when taken
//   i_cfg     in         index, data                           valid & ready (always ready)
//   i_smp     in         sample                                valid & ready
//   o_res     out        detected, peak_hit, energy_hit        valid & ready
//
// Each sample is squared by the bit-serial multiplier, one bit per cycle, and no
// further sample is taken until its square is added to the frame energy. The last
// sample of a frame is followed by the ring update and the two serial steps of the
// threshold product energy_threshold * window * frame_size.
// Reset is synchronous and clears counters, sums and the frame accumulators.
// A finished result waits in the output register while later samples are taken;
// only the next frame end stalls until that register is free.
module frame_peak_energy_detector import fped_pkg::*; #(
    parameter int MAX_WINDOW_FRAMES = DEF_MAX_WINDOW_FRAMES,
    parameter int MAX_FRAME_SIZE    = DEF_MAX_FRAME_SIZE,
    parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fped_cfg_if.sink      i_cfg,
    fped_sample_if.sink   i_smp,
    fped_result_if.source o_res
);

    localparam int FS_W  = $clog2(MAX_FRAME_SIZE + 1);
    localparam int WIN_W = $clog2(MAX_WINDOW_FRAMES + 1);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int FE_W  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAME_SIZE);
    localparam int WS_W  = FE_W + $clog2(MAX_WINDOW_FRAMES);
    localparam int MC_W  = (ENERGY_THR_W + WIN_W > SAMPLE_BITS) ?
                           ENERGY_THR_W + WIN_W : SAMPLE_BITS;
    localparam int MP_A  = (SAMPLE_BITS > WIN_W) ? SAMPLE_BITS : WIN_W;
    localparam int MP_W  = (MP_A > FS_W) ? MP_A : FS_W;
    localparam int PR_W  = MC_W + MP_W;
    localparam int CMP_W = (WS_W > PR_W) ? WS_W : PR_W;

    logic [FS_W-1:0]              frame_size;
    logic [WIN_W-1:0]             window;
    logic [PEAK_START_W-1:0]      peak_start;
    logic signed [PEAK_THR_W-1:0] peak_thr;
    logic [ENERGY_THR_W-1:0]      energy_thr;

    t_state          r_state, n_state;
    logic [FS_W-1:0] r_index, n_index;
    logic            r_peak_flag, n_peak_flag;
    logic [FE_W-1:0] r_frame_energy, n_frame_energy;
    logic            r_peak_hit, n_peak_hit;
    logic            r_energy_hit, n_energy_hit;
    logic            r_out_valid, n_out_valid;
    logic            r_out_detected, n_out_detected;
    logic            r_out_peak, n_out_peak;
    logic            r_out_energy, n_out_energy;

    logic                   mul_start;
    logic [MC_W-1:0]        mul_mcand;
    logic [MP_W-1:0]        mul_mplier;
    logic                   mul_done;
    logic [PR_W-1:0]        mul_product;
    t_win_op                win_op;
    logic [WIN_W-1:0]       frames_seen;
    logic [WS_W-1:0]        window_sum;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   peak_now;
    logic [FS_W-1:0]        index_inc;
    logic                   slot_free;

    fped_cfg_regs #(
        .MAX_WINDOW_FRAMES (MAX_WINDOW_FRAMES),
        .MAX_FRAME_SIZE    (MAX_FRAME_SIZE),
        .FS_W              (FS_W),
        .WIN_W             (WIN_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_frame_size (frame_size),
        .o_window     (window),
        .o_peak_start (peak_start),
        .o_peak_thr   (peak_thr),
        .o_energy_thr (energy_thr)
    );

    fped_sermul #(
        .MC_W (MC_W),
        .MP_W (MP_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mul_mcand),
        .i_mplier  (mul_mplier),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    fped_window #(
        .MAX_WINDOW_FRAMES (MAX_WINDOW_FRAMES),
        .FE_W              (FE_W),
        .WS_W              (WS_W),
        .WIN_W             (WIN_W)
    ) u_win (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (win_op),
        .i_window       (window),
        .i_frame_energy (r_frame_energy),
        .o_frames_seen  (frames_seen),
        .o_window_sum   (window_sum)
    );

    assign mag = i_smp.sample[SAMPLE_BITS-1] ? $unsigned(-i_smp.sample)
                                             : $unsigned(i_smp.sample);
    assign peak_now  = 32'(i_smp.sample) > 32'(peak_thr);
    assign index_inc = r_index + 1'b1;
    assign slot_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_index        = r_index;
        n_peak_flag    = r_peak_flag;
        n_frame_energy = r_frame_energy;
        n_peak_hit     = r_peak_hit;
        n_energy_hit   = r_energy_hit;
        n_out_valid    = r_out_valid && !o_res.ready;
        n_out_detected = r_out_detected;
        n_out_peak     = r_out_peak;
        n_out_energy   = r_out_energy;
        mul_start      = 1'b0;
        mul_mcand      = MC_W'(mag);
        mul_mplier     = MP_W'(mag);
        win_op         = WIN_NOP;
        i_smp.ready    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                i_smp.ready = 1'b1;
                if (i_smp.valid) begin
                    mul_start   = 1'b1;
                    n_peak_flag = r_peak_flag | peak_now;
                    n_state     = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (mul_done) begin
                    n_frame_energy = r_frame_energy + FE_W'(mul_product[SQ_W-1:0]);
                    n_index        = index_inc;
                    n_state        = (index_inc >= frame_size) ? ST_FE_READ : ST_IDLE;
                end
            end
            ST_FE_READ: begin
                win_op     = WIN_READ;
                mul_start  = 1'b1;
                mul_mcand  = MC_W'(energy_thr);
                mul_mplier = MP_W'(window);
                n_state    = ST_FE_EVICT;
            end
            ST_FE_EVICT: begin
                win_op  = WIN_EVICT;
                n_state = ST_FE_COMMIT;
            end
            ST_FE_COMMIT: begin
                win_op  = WIN_COMMIT;
                n_state = ST_THR_W;
            end
            ST_THR_W: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = mul_product[MC_W-1:0];
                    mul_mplier = MP_W'(frame_size);
                    n_state    = ST_THR_FS;
                end
            end
            ST_THR_FS: begin
                if (mul_done) begin
                    n_peak_hit   = r_peak_flag && (32'(frames_seen) >= 32'(peak_start));
                    n_energy_hit = (frames_seen >= window) &&
                                   (CMP_W'(window_sum) > CMP_W'(mul_product));
                    n_state      = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    n_out_valid    = 1'b1;
                    n_out_detected = r_peak_hit || r_energy_hit;
                    n_out_peak     = r_peak_hit;
                    n_out_energy   = r_energy_hit;
                    n_index        = '0;
                    n_peak_flag    = 1'b0;
                    n_frame_energy = '0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index        <= '0;
            r_peak_flag    <= 1'b0;
            r_frame_energy <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_index        <= n_index;
            r_peak_flag    <= n_peak_flag;
            r_frame_energy <= n_frame_energy;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_peak_hit     <= n_peak_hit;
        r_energy_hit   <= n_energy_hit;
        r_out_detected <= n_out_detected;
        r_out_peak     <= n_out_peak;
        r_out_energy   <= n_out_energy;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.detected   = r_out_detected;
    assign o_res.peak_hit   = r_out_peak;
    assign o_res.energy_hit = r_out_energy;

    // The multiplier only finishes while the sequencer is waiting for it.
    ap_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_SQUARE || r_state == ST_THR_W || r_state == ST_THR_FS))
        else $error("multiplier finished outside a waiting state");

    // Handing a result over clears the frame accumulators and fills the output slot.
    ap_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && slot_free) |=>
            (r_index == '0 && !r_peak_flag && r_frame_energy == '0 && r_out_valid))
        else $error("frame state not cleared after result");

    // An energy hit needs a full window.
    ap_energy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && r_energy_hit) |-> (frames_seen >= window))
        else $error("energy hit with a window that is not full");

endmodule
